// ===== sv/aes_pkg.sv =====
package aes_pkg;

    localparam int XW = 24;
    localparam int CW = 24;
    localparam int OPAW = 36;
    localparam int OPBW = 26;
    localparam int PW = OPAW + OPBW;
    localparam int TW = 42;
    localparam int SW = 44;
    localparam int FRAC = 20;
    localparam logic signed [CW-1:0] Q_ONE = 24'sd1048576;
    localparam logic signed [CW-1:0] Q24_MAX = 24'sd8388607;
    localparam logic signed [CW-1:0] Q24_MIN = -24'sd8388608;

    localparam logic [2:0] KIND_BYPASS = 3'd0;
    localparam logic [2:0] KIND_GAIN = 3'd1;
    localparam logic [2:0] KIND_LOWPASS = 3'd2;
    localparam logic [2:0] KIND_HIGHPASS = 3'd3;
    localparam logic [2:0] KIND_ECHO = 3'd4;
    localparam logic [2:0] KIND_CLIP = 3'd5;
    localparam logic [2:0] KIND_GATE = 3'd6;
    localparam logic [2:0] KIND_COMP = 3'd7;

    localparam logic [2:0] REG_KIND = 3'd0;
    localparam logic [2:0] REG_COEF_A = 3'd1;
    localparam logic [2:0] REG_COEF_B = 3'd2;
    localparam logic [2:0] REG_COEF_C = 3'd3;
    localparam logic [2:0] REG_ECHO_LEN = 3'd4;

    typedef struct packed {
        logic [2:0] kind;
        logic signed [CW-1:0] coef_a;
        logic signed [CW-1:0] coef_b;
        logic signed [CW-1:0] coef_c;
        logic [14:0] echo_length;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic restart;
        logic step1;
        logic step2;
        logic commit;
    } cmd_t;

endpackage

// ===== sv/aes_ctrl.sv =====
module aes_ctrl
    import aes_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL1,
        ST_MUL2,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        m_valid_next = m_valid_reg;
        cmd = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.restart = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.step1 = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.step2 = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.commit = 1'b1;
                    m_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== sv/aes_datapath.sv =====
module aes_datapath
    import aes_pkg::*;
#(
    parameter int MAX_ECHO = 32768,
    parameter int SAMPLE_BITS = 24
) (
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  cmd_t cmd,
    input  logic signed [XW-1:0] s_sample_in,
    input  logic s_first,
    output logic signed [XW-1:0] m_sample_out
);

    localparam int AW = (MAX_ECHO > 1) ? $clog2(MAX_ECHO) : 1;
    localparam int DW = 21;
    localparam logic [DW-1:0] DMAX = DW'(MAX_ECHO - 1);
    localparam logic [DW-1:0] DEPTH = DW'(MAX_ECHO);
    localparam logic [AW-1:0] WP_LAST = AW'(MAX_ECHO - 1);
    localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

    logic signed [SAMPLE_BITS-1:0] echo_mem [MAX_ECHO];
    logic signed [SAMPLE_BITS-1:0] mem_q_reg;

    logic signed [XW-1:0] x_reg;
    logic first_reg;
    logic signed [SAMPLE_BITS-1:0] lo_reg;
    logic signed [XW-1:0] li_reg;
    logic signed [CW-1:0] gate_reg;
    logic signed [CW-1:0] gnew_reg;
    logic [15:0] cnt_reg;
    logic [AW-1:0] wp_reg;
    logic signed [TW-1:0] t1_reg;
    logic signed [TW-1:0] t2_reg;
    logic signed [XW-1:0] out_reg;

    logic signed [OPAW-1:0] opa;
    logic signed [OPBW-1:0] opb;
    logic signed [PW-1:0] prod;
    logic signed [TW-1:0] prod_sh;
    logic signed [XW:0] ax;
    logic below_a;
    logic above_a;
    logic [DW-1:0] d;
    logic [DW-1:0] rd_full;
    logic use_echo;
    logic signed [CW-1:0] gsat;
    logic signed [CW-1:0] gnew;
    logic signed [OPAW-1:0] m_val;
    logic signed [OPAW-1:0] s_val;
    logic signed [SW-1:0] y_full;
    logic signed [SW-1:0] t1_ext;
    logic signed [SW-1:0] t2_ext;
    logic signed [SAMPLE_BITS-1:0] y_sat;

    assign ax = x_reg[XW-1] ? -(XW+1)'(x_reg) : (XW+1)'(x_reg);
    assign below_a = ax < (XW+1)'(cfg.coef_a);
    assign above_a = ax > (XW+1)'(cfg.coef_a);

    assign d = ({6'b0, cfg.echo_length} > DMAX) ? DMAX : {6'b0, cfg.echo_length};
    assign use_echo = (d != '0) && ({5'b0, cnt_reg} >= d);
    assign rd_full = ({{(DW-AW){1'b0}}, wp_reg} >= d) ?
                     {{(DW-AW){1'b0}}, wp_reg} - d :
                     {{(DW-AW){1'b0}}, wp_reg} + DEPTH - d;

    always_comb begin
        gsat = (t1_reg > TW'(Q24_MAX)) ? Q24_MAX :
               (t1_reg < TW'(Q24_MIN)) ? Q24_MIN : t1_reg[CW-1:0];
        gnew = gsat;
        if (!below_a && gsat > Q_ONE) begin
            gnew = Q_ONE;
        end
        m_val = OPAW'(cfg.coef_a) + OPAW'(t1_reg);
        s_val = OPAW'(x_reg);
        if (above_a) begin
            s_val = (x_reg > 0) ? m_val : -m_val;
        end
    end

    always_comb begin
        opa = OPAW'(x_reg);
        opb = OPBW'(cfg.coef_a);
        if (cmd.step1) begin
            case (cfg.kind)
                KIND_HIGHPASS: begin
                    opa = OPAW'(lo_reg) + OPAW'(x_reg) - OPAW'(li_reg);
                    opb = OPBW'(cfg.coef_a);
                end
                KIND_GATE: begin
                    opa = OPAW'(gate_reg);
                    opb = below_a ? OPBW'(cfg.coef_b) : OPBW'(cfg.coef_c);
                end
                KIND_COMP: begin
                    opa = OPAW'(ax) - OPAW'(cfg.coef_a);
                    opb = OPBW'(cfg.coef_b);
                end
                default: begin
                    opa = OPAW'(x_reg);
                    opb = OPBW'(cfg.coef_a);
                end
            endcase
        end else begin
            case (cfg.kind)
                KIND_LOWPASS: begin
                    opa = OPAW'(lo_reg);
                    opb = OPBW'(Q_ONE) - OPBW'(cfg.coef_a);
                end
                KIND_ECHO: begin
                    opa = OPAW'(mem_q_reg);
                    opb = OPBW'(cfg.coef_a);
                end
                KIND_GATE: begin
                    opa = OPAW'(x_reg);
                    opb = OPBW'(gnew);
                end
                KIND_COMP: begin
                    opa = s_val;
                    opb = OPBW'(cfg.coef_c);
                end
                default: begin
                    opa = OPAW'(x_reg);
                    opb = OPBW'(cfg.coef_a);
                end
            endcase
        end
    end

    assign prod = PW'(opa) * PW'(opb);
    assign prod_sh = TW'(prod >>> FRAC);

    assign t1_ext = SW'(t1_reg);
    assign t2_ext = SW'(t2_reg);

    always_comb begin
        case (cfg.kind)
            KIND_GAIN: y_full = t1_ext;
            KIND_LOWPASS: y_full = t1_ext + t2_ext;
            KIND_HIGHPASS: y_full = t1_ext;
            KIND_ECHO: y_full = use_echo ? SW'(x_reg) + t2_ext : SW'(x_reg);
            KIND_CLIP: begin
                y_full = t1_ext;
                if (t1_ext > SW'(Q_ONE)) begin
                    y_full = SW'(Q_ONE);
                end else if (t1_ext < -SW'(Q_ONE)) begin
                    y_full = -SW'(Q_ONE);
                end
            end
            KIND_GATE: y_full = t2_ext;
            KIND_COMP: y_full = t2_ext;
            default: y_full = SW'(x_reg);
        endcase
        if (y_full > SMAX) begin
            y_sat = SMAX[SAMPLE_BITS-1:0];
        end else if (y_full < SMIN) begin
            y_sat = SMIN[SAMPLE_BITS-1:0];
        end else begin
            y_sat = y_full[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step1) begin
            mem_q_reg <= echo_mem[rd_full[AW-1:0]];
        end
        if (cmd.commit) begin
            echo_mem[wp_reg] <= y_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            x_reg <= s_sample_in;
            first_reg <= s_first;
        end
        if (cmd.step1) begin
            t1_reg <= prod_sh;
        end
        if (cmd.step2) begin
            t2_reg <= prod_sh;
            gnew_reg <= gnew;
        end
        if (cmd.commit) begin
            out_reg <= XW'(y_sat);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg <= '0;
            li_reg <= '0;
            gate_reg <= Q_ONE;
            cnt_reg <= '0;
            wp_reg <= '0;
        end else if (cmd.restart && first_reg) begin
            lo_reg <= '0;
            li_reg <= '0;
            gate_reg <= Q_ONE;
            cnt_reg <= '0;
            wp_reg <= '0;
        end else if (cmd.commit) begin
            lo_reg <= y_sat;
            li_reg <= x_reg;
            if (cfg.kind == KIND_GATE) begin
                gate_reg <= gnew_reg;
            end
            if (cnt_reg != 16'hFFFF) begin
                cnt_reg <= cnt_reg + 16'd1;
            end
            wp_reg <= (wp_reg == WP_LAST) ? '0 : wp_reg + AW'(1);
        end
    end

    assign m_sample_out = out_reg;

endmodule

// ===== sv/audio_effect_stage.sv =====
// Single effect stage over signed Q3.20 audio samples.
// Input channel: s_valid/s_ready with s_sample_in and s_first; a beat with
//   s_first set restarts filter, gate and echo history before it is used.
// Output channel: m_valid/m_ready with m_sample_out, one beat per input beat,
//   saturated to the sample range.
// Configuration: APB write/read port, registers at 4*i: kind, coef_a,
//   coef_b, coef_c, echo_length. Write only while the stage is idle.
// Each input beat passes the states prep, mul1, mul2 and fin before its result
//   is committed; no new beat is taken until the stage is idle again. The shared
//   multiplier is used twice per sample, and the echo memory read is registered.
// A finished result sits in the output register; while the receiver stalls
//   the stage accepts and computes the next beat, then holds it until the
//   output register frees.
// Reset (synchronous, aresetn low): coefficients to one, kind bypass, echo
//   length zero, history cleared. The echo memory is not cleared; a read entry
//   is only used after it has been written.
module audio_effect_stage
    import aes_pkg::*;
#(
    parameter int MAX_ECHO = 32768,
    parameter int SAMPLE_BITS = 24
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [4:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    input  logic s_valid,
    output logic s_ready,
    input  logic signed [XW-1:0] s_sample_in,
    input  logic s_first,
    output logic m_valid,
    input  logic m_ready,
    output logic signed [XW-1:0] m_sample_out
);

    cfg_t cfg_reg;
    cmd_t cmd;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kind <= KIND_BYPASS;
            cfg_reg.coef_a <= Q_ONE;
            cfg_reg.coef_b <= Q_ONE;
            cfg_reg.coef_c <= Q_ONE;
            cfg_reg.echo_length <= '0;
        end else if (wr_en) begin
            case (paddr[4:2])
                REG_KIND: cfg_reg.kind <= pwdata[2:0];
                REG_COEF_A: cfg_reg.coef_a <= pwdata[CW-1:0];
                REG_COEF_B: cfg_reg.coef_b <= pwdata[CW-1:0];
                REG_COEF_C: cfg_reg.coef_c <= pwdata[CW-1:0];
                REG_ECHO_LEN: cfg_reg.echo_length <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_KIND: prdata = {29'b0, cfg_reg.kind};
            REG_COEF_A: prdata = {8'b0, cfg_reg.coef_a};
            REG_COEF_B: prdata = {8'b0, cfg_reg.coef_b};
            REG_COEF_C: prdata = {8'b0, cfg_reg.coef_c};
            REG_ECHO_LEN: prdata = {17'b0, cfg_reg.echo_length};
            default: prdata = '0;
        endcase
    end

    aes_ctrl u_ctrl (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .cmd(cmd)
    );

    aes_datapath #(
        .MAX_ECHO(MAX_ECHO),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_datapath (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg(cfg_reg),
        .cmd(cmd),
        .s_sample_in(s_sample_in),
        .s_first(s_first),
        .m_sample_out(m_sample_out)
    );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import aes_pkg::*;

    typedef struct packed {
        logic [2:0] kind;
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] c;
        logic [14:0] len;
    } setting_t;

    typedef struct packed {
        setting_t s;
        logic signed [XW-1:0] x;
        logic f;
        logic typed;
        logic signed [XW-1:0] y;
    } row_t;

    localparam int ECHO_DEPTH = 32768;
    localparam logic signed [XW-1:0] XMAX = Q24_MAX;
    localparam logic signed [XW-1:0] XMIN = Q24_MIN;
    localparam logic [4:0] ADDR_BAD = 5'd20;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0, s_ready;
    logic signed [XW-1:0] s_sample_in = '0;
    logic s_first = 1'b0;
    logic m_valid, m_ready = 1'b0;
    logic signed [XW-1:0] m_sample_out;

    audio_effect_stage dut (.*);

    setting_t cur;
    logic signed [XW-1:0] prev_out, prev_in, gate_g;
    int unsigned since_restart, wr_idx;
    logic signed [XW-1:0] echo_mem [ECHO_DEPTH];
    logic signed [XW-1:0] expected_samples [$];
    int errors = 0;
    bit steady = 1'b0;
    row_t rows [24];

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3000000;
        $display("status: fail");
        $finish;
    end

    function automatic longint qmul(longint p, longint q);
        return (p * q) >>> FRAC;
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic signed [XW-1:0] effect_out(logic signed [XW-1:0] xin, logic f);
        longint x, y, ax, g, m, s;
        int unsigned d;
        x = longint'(xin);
        ax = x < 0 ? -x : x;
        if (f) begin
            prev_out = '0;
            prev_in = '0;
            gate_g = Q_ONE;
            since_restart = 0;
            wr_idx = 0;
        end
        case (cur.kind)
            KIND_GAIN: y = qmul(x, cur.a);
            KIND_LOWPASS: y = qmul(x, cur.a) + qmul(prev_out, longint'(Q_ONE) - cur.a);
            KIND_HIGHPASS: y = qmul(cur.a, longint'(prev_out) + x - prev_in);
            KIND_ECHO: begin
                d = 32'(cur.len);
                y = x;
                if (d >= 1 && since_restart >= d)
                    y = x + qmul(cur.a, echo_mem[(wr_idx + ECHO_DEPTH - d) % ECHO_DEPTH]);
            end
            KIND_CLIP: y = clampl(qmul(x, cur.a), -longint'(Q_ONE), Q_ONE);
            KIND_GATE: begin
                if (ax < cur.a) begin
                    gate_g = XW'(clampl(qmul(gate_g, cur.b), Q24_MIN, Q24_MAX));
                end else begin
                    g = clampl(qmul(gate_g, cur.c), Q24_MIN, Q24_MAX);
                    gate_g = XW'(g < Q_ONE ? g : longint'(Q_ONE));
                end
                y = qmul(x, gate_g);
            end
            KIND_COMP: begin
                s = x;
                if (ax > cur.a) begin
                    m = longint'(cur.a) + qmul(ax - cur.a, cur.b);
                    s = x > 0 ? m : -m;
                end
                y = qmul(s, cur.c);
            end
            default: y = x;
        endcase
        y = clampl(y, Q24_MIN, Q24_MAX);
        prev_out = XW'(y);
        prev_in = xin;
        echo_mem[wr_idx] = XW'(y);
        wr_idx = (wr_idx + 1) % ECHO_DEPTH;
        if (since_restart < 65535)
            since_restart++;
        return XW'(y);
    endfunction

    always @(posedge aclk) begin
        m_ready <= steady || $urandom_range(99) >= 26;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected beat, actual %0d", $time, m_sample_out);
                errors++;
            end else begin
                if (m_sample_out !== expected_samples[0]) begin
                    $display("%0t: sample_out expected %0d actual %0d", $time,
                             expected_samples[0], m_sample_out);
                    errors++;
                end
                void'(expected_samples.pop_front());
            end
        end
    end

    task automatic reg_write(logic [4:0] addr, logic [31:0] data, int w);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= w > 0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (w > 0) begin
            @(posedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            if (((prdata ^ data) & ((32'd1 << w) - 32'd1)) != 32'd0) begin
                $display("%0t: reg %0d expected %0h actual %0h", $time, addr, data, prdata);
                errors++;
            end
            psel <= 1'b0;
            penable <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic drain();
        while (expected_samples.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic configure(setting_t s);
        s_valid <= 1'b0;
        drain();
        reg_write({REG_KIND, 2'b00}, 32'(s.kind), 3);
        reg_write({REG_COEF_A, 2'b00}, 32'(s.a), 24);
        reg_write({REG_COEF_B, 2'b00}, 32'(s.b), 24);
        reg_write({REG_COEF_C, 2'b00}, 32'(s.c), 24);
        reg_write({REG_ECHO_LEN, 2'b00}, 32'(s.len), 15);
        reg_write(ADDR_BAD, $urandom, 0);
        cur = s;
    endtask

    task automatic push(logic signed [XW-1:0] x, logic f, logic typed, logic signed [XW-1:0] y);
        logic signed [XW-1:0] p;
        while (!steady && $urandom_range(99) < 26) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample_in <= x;
        s_first <= f;
        do @(posedge aclk); while (!(s_valid && s_ready));
        p = effect_out(x, f);
        expected_samples.push_back(typed ? y : p);
    endtask

    function automatic logic signed [XW-1:0] rnd_sample();
        case ($urandom_range(5))
            0: return XMAX;
            1: return XMIN;
            2: return XW'($signed($urandom_range(131071)) - 65536);
            3: return XW'($signed($urandom_range(4194303)) - 2097152);
            default: return XW'($urandom);
        endcase
    endfunction

    function automatic logic signed [CW-1:0] rnd_coef();
        case ($urandom_range(6))
            0: return XMAX;
            1: return XMIN;
            2: return Q_ONE;
            3: return CW'($urandom_range(1048576));
            4: return CW'($urandom_range(131072));
            default: return CW'($urandom);
        endcase
    endfunction

    initial begin
        setting_t s;
        setting_t base;
        int n;
        base = '{KIND_BYPASS, Q_ONE, Q_ONE, Q_ONE, 15'd0};
        cur = base;
        prev_out = '0;
        prev_in = '0;
        gate_g = Q_ONE;
        since_restart = 0;
        wr_idx = 0;

        rows[0] = '{base, XMAX, 1'b0, 1'b1, XMAX};
        rows[1] = '{base, XMIN, 1'b0, 1'b1, XMIN};
        rows[2] = '{'{KIND_GAIN, XMAX, Q_ONE, Q_ONE, 15'd0}, XMAX, 1'b0, 1'b1, XMAX};
        rows[3] = '{'{KIND_GAIN, XMAX, Q_ONE, Q_ONE, 15'd0}, XMIN, 1'b0, 1'b1, XMIN};
        rows[4] = '{'{KIND_GAIN, XMIN, Q_ONE, Q_ONE, 15'd0}, XMIN, 1'b1, 1'b1, XMAX};
        rows[5] = '{'{KIND_CLIP, Q_ONE, Q_ONE, Q_ONE, 15'd0}, XMAX, 1'b0, 1'b1, Q_ONE};
        rows[6] = '{'{KIND_CLIP, Q_ONE, Q_ONE, Q_ONE, 15'd0}, XMIN, 1'b0, 1'b1, -Q_ONE};
        rows[7] = '{'{KIND_LOWPASS, 24'sd262144, Q_ONE, Q_ONE, 15'd0}, XMAX, 1'b1, 1'b0, '0};
        rows[8] = '{'{KIND_LOWPASS, 24'sd262144, Q_ONE, Q_ONE, 15'd0}, XMIN, 1'b0, 1'b0, '0};
        rows[9] = '{'{KIND_HIGHPASS, 24'sd996147, Q_ONE, Q_ONE, 15'd0}, XMAX, 1'b1, 1'b0, '0};
        rows[10] = '{'{KIND_HIGHPASS, 24'sd996147, Q_ONE, Q_ONE, 15'd0}, XMIN, 1'b0, 1'b0, '0};
        rows[11] = '{'{KIND_ECHO, 24'sd524288, Q_ONE, Q_ONE, 15'd0}, 24'sd12345, 1'b0, 1'b1,
                     24'sd12345};
        rows[12] = '{'{KIND_ECHO, 24'sd524288, Q_ONE, Q_ONE, 15'd2}, XMAX, 1'b1, 1'b0, '0};
        rows[13] = '{'{KIND_ECHO, 24'sd524288, Q_ONE, Q_ONE, 15'd2}, XMIN, 1'b0, 1'b0, '0};
        rows[14] = '{'{KIND_ECHO, 24'sd524288, Q_ONE, Q_ONE, 15'd2}, XMAX, 1'b0, 1'b0, '0};
        rows[15] = '{'{KIND_ECHO, 24'sd524288, Q_ONE, Q_ONE, 15'd2}, 24'sd1000, 1'b0, 1'b0, '0};
        rows[16] = '{'{KIND_ECHO, XMAX, Q_ONE, Q_ONE, 15'd32767}, XMIN, 1'b1, 1'b1, XMIN};
        rows[17] = '{'{KIND_GATE, 24'sd10486, 24'sd996147, XMAX, 15'd0}, 24'sd100, 1'b1,
                     1'b0, '0};
        rows[18] = '{'{KIND_GATE, 24'sd10486, 24'sd996147, XMAX, 15'd0}, XMAX, 1'b0, 1'b0, '0};
        rows[19] = '{'{KIND_GATE, 24'sd10486, XMAX, XMAX, 15'd0}, 24'sd5, 1'b0, 1'b0, '0};
        rows[20] = '{'{KIND_GATE, 24'sd10486, XMAX, XMAX, 15'd0}, XMIN, 1'b0, 1'b0, '0};
        rows[21] = '{'{KIND_COMP, 24'sd524288, 24'sd262144, 24'sd1572864, 15'd0}, XMAX, 1'b0,
                     1'b0, '0};
        rows[22] = '{'{KIND_COMP, 24'sd524288, 24'sd262144, 24'sd1572864, 15'd0}, XMIN, 1'b0,
                     1'b0, '0};
        rows[23] = '{'{KIND_COMP, 24'sd524288, 24'sd262144, 24'sd1572864, 15'd0}, '0, 1'b0,
                     1'b0, '0};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            if (rows[i].s != cur)
                configure(rows[i].s);
            push(rows[i].x, rows[i].f, rows[i].typed, rows[i].y);
        end

        n = 0;
        while (n < 1650) begin
            s.kind = 3'($urandom_range(7));
            s.a = rnd_coef();
            s.b = rnd_coef();
            s.c = rnd_coef();
            s.len = $urandom_range(3) == 0 ? 15'($urandom) : 15'($urandom_range(1, 40));
            if (s.kind == KIND_GATE || s.kind == KIND_COMP)
                s.a = $urandom_range(1) ? CW'($urandom_range(1048576)) : s.a;
            configure(s);
            repeat ($urandom_range(40, 120)) begin
                steady = n >= 700 && n < 950;
                push(rnd_sample(), $urandom_range(29) == 0, 1'b0, '0);
                n++;
            end
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        drain();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
